// ----- rtl/trs_pkg.sv -----
// ----------------------------------------------------------------------------
// trs_pkg
// shared constants, command struct and micro-step table of the trs model
// matrix builder
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int WORD_WIDTH   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int ANG_BITS     = 30;
	localparam int ANG_SH       = ANG_BITS - FRAC_BITS;

	// angle datapath widths
	localparam int RED_W  = WORD_WIDTH + ANG_SH + 1;
	localparam int RED_STEPS = 14;
	localparam int R_W    = 35;
	localparam int CD_W   = 34;
	localparam int TRIG_W = CD_W - ANG_SH;

	// product datapath widths
	localparam int MEM_W   = 36;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int MEM_DEPTH = 17;
	localparam int ADDR_W  = 5;
	localparam int RES_N   = 11;
	localparam int NSTEPS  = 26;

	localparam logic signed [47:0] K_GAIN    = 48'sd652032874;
	localparam logic signed [47:0] PI_A      = 48'sd3373259426;
	localparam logic signed [47:0] TWO_PI_A  = 48'sd6746518852;
	localparam logic signed [47:0] HALF_PI_A = 48'sd1686629713;
	localparam logic signed [MUL_W-1:0] ONE_Q = MUL_W'(1) <<< FRAC_BITS;

	localparam logic [1:0] OP_POS = 2'd0;
	localparam logic [1:0] OP_ROT = 2'd1;
	localparam logic [1:0] OP_SCL = 2'd2;

	localparam logic [2:0] KIND_COL3  = 3'd3;
	localparam logic [2:0] KIND_FRONT = 3'd4;
	localparam logic [2:0] KIND_RIGHT = 3'd5;

	localparam logic [2:0] B_MEM  = 3'd0;
	localparam logic [2:0] B_ONE  = 3'd1;
	localparam logic [2:0] B_SCL0 = 3'd2;
	localparam logic [2:0] B_SCL1 = 3'd3;
	localparam logic [2:0] B_SCL2 = 3'd4;

	// scratch memory map
	localparam logic [ADDR_W-1:0] A_SX = 5'd0;
	localparam logic [ADDR_W-1:0] A_CX = 5'd1;
	localparam logic [ADDR_W-1:0] A_SY = 5'd2;
	localparam logic [ADDR_W-1:0] A_CY = 5'd3;
	localparam logic [ADDR_W-1:0] A_SZ = 5'd4;
	localparam logic [ADDR_W-1:0] A_CZ = 5'd5;
	localparam logic [ADDR_W-1:0] A_T1 = 5'd6;
	localparam logic [ADDR_W-1:0] A_T2 = 5'd7;
	localparam logic [ADDR_W-1:0] A_RM = 5'd8;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
		32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
		32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128,
		32'd64, 32'd32, 32'd16, 32'd8,
		32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef struct packed {
		logic [ADDR_W-1:0] a_addr;
		logic [2:0]        b_sel;
		logic [ADDR_W-1:0] b_addr;
		logic              neg;
		logic              accum;
		logic              to_res;
		logic [ADDR_W-1:0] dst;
	} step_t;

	localparam step_t STEP_TAB [NSTEPS] = '{
		'{A_SY, B_MEM, A_CZ, 1'b0, 1'b0, 1'b0, A_T1},
		'{A_SY, B_MEM, A_SZ, 1'b0, 1'b0, 1'b0, A_T2},
		'{A_CY, B_MEM, A_CZ, 1'b0, 1'b0, 1'b0, 5'd8},
		'{A_CY, B_MEM, A_SZ, 1'b1, 1'b0, 1'b0, 5'd9},
		'{A_SY, B_ONE, A_SX, 1'b0, 1'b0, 1'b0, 5'd10},
		'{A_CX, B_MEM, A_SZ, 1'b0, 1'b0, 1'b0, 5'd11},
		'{A_SX, B_MEM, A_T1, 1'b0, 1'b1, 1'b0, 5'd11},
		'{A_CX, B_MEM, A_CZ, 1'b0, 1'b0, 1'b0, 5'd12},
		'{A_SX, B_MEM, A_T2, 1'b1, 1'b1, 1'b0, 5'd12},
		'{A_SX, B_MEM, A_CY, 1'b1, 1'b0, 1'b0, 5'd13},
		'{A_SX, B_MEM, A_SZ, 1'b0, 1'b0, 1'b0, 5'd14},
		'{A_CX, B_MEM, A_T1, 1'b1, 1'b1, 1'b0, 5'd14},
		'{A_SX, B_MEM, A_CZ, 1'b0, 1'b0, 1'b0, 5'd15},
		'{A_CX, B_MEM, A_T2, 1'b0, 1'b1, 1'b0, 5'd15},
		'{A_CX, B_MEM, A_CY, 1'b0, 1'b0, 1'b0, 5'd16},
		'{5'd8,  B_SCL0, A_SX, 1'b0, 1'b0, 1'b1, 5'd0},
		'{5'd11, B_SCL0, A_SX, 1'b0, 1'b0, 1'b1, 5'd1},
		'{5'd14, B_SCL0, A_SX, 1'b0, 1'b0, 1'b1, 5'd2},
		'{5'd9,  B_SCL1, A_SX, 1'b0, 1'b0, 1'b1, 5'd3},
		'{5'd12, B_SCL1, A_SX, 1'b0, 1'b0, 1'b1, 5'd4},
		'{5'd15, B_SCL1, A_SX, 1'b0, 1'b0, 1'b1, 5'd5},
		'{5'd10, B_SCL2, A_SX, 1'b0, 1'b0, 1'b1, 5'd6},
		'{5'd13, B_SCL2, A_SX, 1'b0, 1'b0, 1'b1, 5'd7},
		'{5'd16, B_SCL2, A_SX, 1'b0, 1'b0, 1'b1, 5'd8},
		'{A_CY, B_MEM, A_CX, 1'b0, 1'b0, 1'b1, 5'd9},
		'{A_CY, B_MEM, A_SX, 1'b0, 1'b0, 1'b1, 5'd10}
	};

	typedef struct packed {
		logic       load_in;
		logic       t_load;
		logic       t_red;
		logic       t_wrap;
		logic       t_fold;
		logic       t_iter;
		logic       w_sin;
		logic       w_cos;
		logic       s_rd;
		logic       s_mul;
		logic       s_wb;
		logic       out_load;
		logic [1:0] ang;
		logic [4:0] cnt;
		logic [4:0] step;
		logic [2:0] kind;
	} cmd_t;

	function automatic logic [WORD_WIDTH-1:0] sat_word(input logic signed [MEM_W-1:0] v);
		logic signed [MEM_W-1:0] hi;
		logic signed [MEM_W-1:0] lo;
		hi = MEM_W'((64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1);
		lo = -hi - MEM_W'(1);
		if (v > hi) begin
			return hi[WORD_WIDTH-1:0];
		end else if (v < lo) begin
			return lo[WORD_WIDTH-1:0];
		end
		return v[WORD_WIDTH-1:0];
	endfunction

endpackage

// ----- rtl/trs_ctrl.sv -----
// ----------------------------------------------------------------------------
// trs_ctrl
// sequencer: trig per angle, product micro-steps, six output beats
// ----------------------------------------------------------------------------
module trs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output trs_pkg::cmd_t cmd
);
	import trs_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOAD = 4'd1;
	localparam logic [3:0] ST_RED  = 4'd2;
	localparam logic [3:0] ST_WRAP = 4'd3;
	localparam logic [3:0] ST_FOLD = 4'd4;
	localparam logic [3:0] ST_ITER = 4'd5;
	localparam logic [3:0] ST_WSIN = 4'd6;
	localparam logic [3:0] ST_WCOS = 4'd7;
	localparam logic [3:0] ST_RD   = 4'd8;
	localparam logic [3:0] ST_MUL  = 4'd9;
	localparam logic [3:0] ST_WB   = 4'd10;
	localparam logic [3:0] ST_EMIT = 4'd11;

	logic [3:0] state_q;
	logic [1:0] ang_q;
	logic [4:0] cnt_q;
	logic [4:0] step_q;
	logic [2:0] kind_q;
	logic       mvalid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign out_free = !mvalid_q || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = s_tvalid && s_tready;
		cmd.t_load   = (state_q == ST_LOAD);
		cmd.t_red    = (state_q == ST_RED);
		cmd.t_wrap   = (state_q == ST_WRAP);
		cmd.t_fold   = (state_q == ST_FOLD);
		cmd.t_iter   = (state_q == ST_ITER);
		cmd.w_sin    = (state_q == ST_WSIN);
		cmd.w_cos    = (state_q == ST_WCOS);
		cmd.s_rd     = (state_q == ST_RD);
		cmd.s_mul    = (state_q == ST_MUL);
		cmd.s_wb     = (state_q == ST_WB);
		cmd.out_load = (state_q == ST_EMIT) && out_free;
		cmd.ang      = ang_q;
		cmd.cnt      = cnt_q;
		cmd.step     = step_q;
		cmd.kind     = kind_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ang_q    <= '0;
			cnt_q    <= '0;
			step_q   <= '0;
			kind_q   <= '0;
			mvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ang_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= 5'(RED_STEPS - 1);
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (cnt_q == '0) begin
						state_q <= ST_WRAP;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_WRAP: state_q <= ST_FOLD;
				ST_FOLD: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= ST_WSIN;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_WSIN: state_q <= ST_WCOS;
				ST_WCOS: begin
					if (ang_q == 2'd2) begin
						step_q  <= '0;
						state_q <= ST_RD;
					end else begin
						ang_q   <= ang_q + 2'd1;
						state_q <= ST_LOAD;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WB;
				ST_WB: begin
					if (step_q == 5'(NSTEPS - 1)) begin
						kind_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						step_q  <= step_q + 5'd1;
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (kind_q == KIND_RIGHT) begin
							state_q <= ST_IDLE;
						end else begin
							kind_q <= kind_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/trs_dp.sv -----
// ----------------------------------------------------------------------------
// trs_dp
// datapath: vector registers, cordic unit, scratch memory, shared
// multiplier and output beat register
// ----------------------------------------------------------------------------
module trs_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  trs_pkg::cmd_t cmd,
	input  logic [95:0]   s_tdata,
	input  logic [1:0]    s_tuser,
	output logic [127:0]  m_tdata,
	output logic [3:0]    m_tuser,
	output logic          m_tlast
);
	import trs_pkg::*;

	logic signed [WORD_WIDTH-1:0] pos_q [3];
	logic signed [WORD_WIDTH-1:0] rot_q [3];
	logic signed [WORD_WIDTH-1:0] scl_q [3];

	logic [RED_W-1:0]         red_q;
	logic                     asign_q;
	logic signed [R_W-1:0]    r_q;
	logic signed [CD_W-1:0]   x_q, y_q, z_q;
	logic                     negc_q;
	logic signed [TRIG_W-1:0] sx_q, cx_q, sy_q, cy_q;

	logic signed [MEM_W-1:0]  mem [MEM_DEPTH];
	logic signed [MEM_W-1:0]  rda_s1, rdb_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [MEM_W-1:0]  acc_q;
	logic signed [MEM_W-1:0]  res_q [RES_N];

	logic [127:0] odata_q;
	logic [3:0]   ouser_q;
	logic         olast_q;

	step_t                    st;
	logic signed [WORD_WIDTH-1:0] ang_in;
	logic [WORD_WIDTH:0]      mag;
	logic [RED_W-1:0]         red_cmp;
	logic signed [R_W-1:0]    r_raw, r_wrap;
	logic signed [CD_W-1:0]   dx, dy, atan_v;
	logic signed [TRIG_W-1:0] sin_r, cos_r;
	logic signed [CD_W-1:0]   cos_x;
	logic signed [MUL_W-1:0]  opb;
	logic signed [PROD_W-FRAC_BITS-1:0] prod_r;
	logic signed [MEM_W-1:0]  term, acc_new;
	logic signed [MEM_W-1:0]  nsx, ncx, psx, pcx;

	assign st     = STEP_TAB[cmd.step];
	assign ang_in = rot_q[cmd.ang];
	assign mag    = ang_in[WORD_WIDTH-1] ? (WORD_WIDTH+1)'(-$signed({ang_in[WORD_WIDTH-1], ang_in}))
	                                     : (WORD_WIDTH+1)'($signed({1'b0, ang_in}));
	assign red_cmp = RED_W'(TWO_PI_A) << cmd.cnt;
	assign r_raw   = asign_q ? -R_W'($signed({1'b0, red_q})) : R_W'($signed({1'b0, red_q}));

	always_comb begin
		r_wrap = r_raw;
		if (r_raw > R_W'(PI_A)) begin
			r_wrap = r_raw - R_W'(TWO_PI_A);
		end else if (r_raw < -R_W'(PI_A)) begin
			r_wrap = r_raw + R_W'(TWO_PI_A);
		end
	end

	assign dx     = y_q >>> cmd.cnt;
	assign dy     = x_q >>> cmd.cnt;
	assign atan_v = CD_W'($signed({1'b0, ATAN_TAB[cmd.cnt]}));
	assign cos_x  = negc_q ? -x_q : x_q;
	assign sin_r  = TRIG_W'((y_q + (CD_W'(1) <<< (ANG_SH - 1))) >>> ANG_SH);
	assign cos_r  = TRIG_W'((cos_x + (CD_W'(1) <<< (ANG_SH - 1))) >>> ANG_SH);

	always_comb begin
		case (st.b_sel)
			B_MEM:   opb = rdb_s1[MUL_W-1:0];
			B_ONE:   opb = ONE_Q;
			B_SCL0:  opb = MUL_W'(scl_q[0]);
			B_SCL1:  opb = MUL_W'(scl_q[1]);
			B_SCL2:  opb = MUL_W'(scl_q[2]);
			default: opb = '0;
		endcase
	end

	assign prod_r  = (PROD_W-FRAC_BITS)'((prod_s2 + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
	assign term    = st.neg ? -MEM_W'(prod_r) : MEM_W'(prod_r);
	assign acc_new = (st.accum ? acc_q : '0) + term;

	// input beat and vectors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				rot_q[i] <= '0;
				scl_q[i] <= WORD_WIDTH'(1) <<< FRAC_BITS;
			end
		end else if (cmd.load_in) begin
			for (int i = 0; i < 3; i++) begin
				case (s_tuser)
					OP_POS:  pos_q[i] <= s_tdata[i*WORD_WIDTH +: WORD_WIDTH];
					OP_ROT:  rot_q[i] <= s_tdata[i*WORD_WIDTH +: WORD_WIDTH];
					OP_SCL:  scl_q[i] <= s_tdata[i*WORD_WIDTH +: WORD_WIDTH];
					default: ;
				endcase
			end
		end
	end

	// cordic unit
	always_ff @(posedge clk) begin
		if (cmd.t_load) begin
			red_q   <= RED_W'({mag, ANG_SH'(0)});
			asign_q <= ang_in[WORD_WIDTH-1];
		end
		if (cmd.t_red && red_q >= red_cmp) begin
			red_q <= red_q - red_cmp;
		end
		if (cmd.t_wrap) begin
			r_q <= r_wrap;
		end
		if (cmd.t_fold) begin
			x_q <= CD_W'(K_GAIN);
			y_q <= '0;
			if (r_q > R_W'(HALF_PI_A)) begin
				z_q    <= CD_W'(R_W'(PI_A) - r_q);
				negc_q <= 1'b1;
			end else if (r_q < -R_W'(HALF_PI_A)) begin
				z_q    <= CD_W'(-R_W'(PI_A) - r_q);
				negc_q <= 1'b1;
			end else begin
				z_q    <= CD_W'(r_q);
				negc_q <= 1'b0;
			end
		end
		if (cmd.t_iter) begin
			if (!z_q[CD_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
		if (cmd.w_sin) begin
			case (cmd.ang)
				2'd0:    sx_q <= sin_r;
				2'd1:    sy_q <= sin_r;
				default: ;
			endcase
		end
		if (cmd.w_cos) begin
			case (cmd.ang)
				2'd0:    cx_q <= cos_r;
				2'd1:    cy_q <= cos_r;
				default: ;
			endcase
		end
	end

	// scratch memory, one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.w_sin) begin
			mem[{2'b00, cmd.ang, 1'b0}] <= MEM_W'(sin_r);
		end else if (cmd.w_cos) begin
			mem[{2'b00, cmd.ang, 1'b1}] <= MEM_W'(cos_r);
		end else if (cmd.s_wb && !st.to_res) begin
			mem[st.dst] <= acc_new;
		end
		if (cmd.s_rd) begin
			rda_s1 <= mem[st.a_addr];
			rdb_s1 <= mem[st.b_addr];
		end
	end

	// shared multiplier and writeback
	always_ff @(posedge clk) begin
		if (cmd.s_mul) begin
			prod_s2 <= $signed(rda_s1[MUL_W-1:0]) * opb;
		end
		if (cmd.s_wb) begin
			acc_q <= acc_new;
			if (st.to_res) begin
				res_q[st.dst[3:0]] <= acc_new;
			end
		end
	end

	// right vector terms
	assign psx = MEM_W'(sx_q);
	assign pcx = MEM_W'(cx_q);
	assign nsx = -psx;
	assign ncx = -pcx;

	// output beat
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ouser_q <= {(cmd.kind == KIND_RIGHT) && (cy_q == '0), cmd.kind};
			olast_q <= (cmd.kind == KIND_RIGHT);
			case (cmd.kind)
				3'd0: odata_q <= {WORD_WIDTH'(0), sat_word(res_q[2]), sat_word(res_q[1]),
				                  sat_word(res_q[0])};
				3'd1: odata_q <= {WORD_WIDTH'(0), sat_word(res_q[5]), sat_word(res_q[4]),
				                  sat_word(res_q[3])};
				3'd2: odata_q <= {WORD_WIDTH'(0), sat_word(res_q[8]), sat_word(res_q[7]),
				                  sat_word(res_q[6])};
				KIND_COL3: odata_q <= {WORD_WIDTH'(1) << FRAC_BITS, pos_q[2], pos_q[1], pos_q[0]};
				KIND_FRONT: odata_q <= {WORD_WIDTH'(0), sat_word(res_q[10]), sat_word(MEM_W'(sy_q)),
				                        sat_word(res_q[9])};
				KIND_RIGHT: begin
					if (cy_q == '0) begin
						odata_q <= '0;
					end else if (!cy_q[TRIG_W-1]) begin
						odata_q <= {WORD_WIDTH'(0), sat_word(pcx), WORD_WIDTH'(0), sat_word(nsx)};
					end else begin
						odata_q <= {WORD_WIDTH'(0), sat_word(ncx), WORD_WIDTH'(0), sat_word(psx)};
					end
				end
				default: odata_q <= '0;
			endcase
		end
	end

	assign m_tdata = odata_q;
	assign m_tuser = ouser_q;
	assign m_tlast = olast_q;

endmodule

// ----- rtl/trs_model_matrix_builder.sv -----
// ----------------------------------------------------------------------------
// trs_model_matrix_builder
// translate / rotate (euler x, y, z) / scale model matrix builder
// ----------------------------------------------------------------------------
// input channel s_*: one beat sets position, rotation or scale (s_tuser) to
//   the three q16.16 values in s_tdata, then the matrix is rebuilt
// output channel m_*: six beats per input, matrix columns 0..3, then front,
//   then right; m_tlast marks the right vector beat
// sequence: after the input beat, each of the three angles runs through
//   the cordic unit (14 reduction steps, 16 rotation steps), then 26
//   product steps, each a read, multiply and writeback, run through the
//   single shared multiplier and scratch memory
// busy: no new input is taken until the right vector beat is issued;
//   s_tready is high only while the sequencer is idle
// reset: position and rotation clear to zero, scale to one; no beat pending
// stall: a held output beat stalls the sequencer until it is taken
// ----------------------------------------------------------------------------
module trs_model_matrix_builder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // value_x, value_y, value_z
	input  logic [1:0]   s_tuser,   // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // elem_0, elem_1, elem_2, elem_3
	output logic [3:0]   m_tuser,   // vector_kind, degenerate
	output logic         m_tlast
);
	import trs_pkg::*;

	cmd_t cmd;

	trs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	trs_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ----- rtl/trs_checker.sv -----
// ----------------------------------------------------------------------------
// trs_checker
// port-level checks of the trs model matrix builder
// ----------------------------------------------------------------------------
module trs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [3:0]   m_tuser,
	input logic         m_tlast
);

	// held beat stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output beat dropped");

	// busy after taking an input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("input taken while busy");

	// last beat is the right vector
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[2:0] == 3'd5) else $error("last on wrong kind");

	// degenerate flag only on the right vector
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tlast) else $error("degenerate on wrong kind");

endmodule

bind trs_model_matrix_builder trs_checker u_trs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
